>>> design/b64d_pkg.sv
// Shared types and constants for the base64 stream decoder.
// Holds the character map, the flush builder and the command word.
// No dependencies.
package b64d_pkg;

    localparam logic [6:0] CODE_SKIP = 7'd64;
    localparam logic [6:0] CODE_PAD  = 7'd65;
    localparam logic [6:0] CODE_BAD  = 7'd66;

    // One command word: up to three results that one character causes.
    typedef struct packed {
        logic [23:0] data;   // first byte in the top bits
        logic [1:0]  cnt;    // number of results, 1..3
        logic        valid;  // results carry bytes
        logic        err;    // single error result
        logic        last;   // final result closes the message
    } t_cmd;

    function automatic logic [6:0] map_char(input logic [7:0] ch);
        logic [6:0] code;
        case (ch) inside
            [8'h41:8'h5A]: code = 7'(ch - 8'h41);
            [8'h61:8'h7A]: code = 7'(ch - 8'h61 + 8'd26);
            [8'h30:8'h39]: code = 7'(ch - 8'h30 + 8'd52);
            8'h2B:         code = 7'd62;
            8'h2F:         code = 7'd63;
            8'h09:         code = CODE_SKIP;
            8'h3D:         code = CODE_PAD;
            default:       code = CODE_BAD;
        endcase
        return code;
    endfunction

    // Closing results for the pending sextets.
    function automatic t_cmd flush_cmd(input logic [17:0] acc, input logic [1:0] cnt);
        t_cmd c;
        c.err  = 1'b0;
        c.last = 1'b1;
        case (cnt)
            2'd3: begin
                c.data  = {acc[17:10], acc[9:2], 8'h00};
                c.cnt   = 2'd2;
                c.valid = 1'b1;
            end
            2'd2: begin
                c.data  = {acc[11:4], 16'h0000};
                c.cnt   = 2'd1;
                c.valid = 1'b1;
            end
            default: begin
                c.data  = 24'h000000;
                c.cnt   = 2'd1;
                c.valid = 1'b0;
            end
        endcase
        return c;
    endfunction

endpackage

>>> design/b64d_front.sv
// Front end: accepts characters, decodes them and tracks the sextet group.
// Emits one command word per character that yields results. Uses b64d_pkg.
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_char_code,
    input  logic             i_end_of_text,
    output logic             o_cmd_push,
    output b64d_pkg::t_cmd   o_cmd
);

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_pad, n_pad;
    logic        r_err, n_err;

    logic [6:0]     w_code;
    logic [17:0]    w_acc;
    logic [1:0]     w_cnt;
    logic           w_has;
    b64d_pkg::t_cmd w_cmd;

    assign w_code = b64d_pkg::map_char(i_char_code);

    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_pad = r_pad;
        n_err = r_err;
        w_acc = r_acc;
        w_cnt = r_cnt;
        w_has = 1'b0;
        w_cmd = '0;
        if (r_err) begin
            // drop the rest of the message
            if (i_end_of_text) begin
                n_err = 1'b0;
            end
        end else if (r_pad) begin
            if (i_end_of_text) begin
                w_cmd = b64d_pkg::flush_cmd(r_acc, r_cnt);
                w_has = 1'b1;
                n_acc = '0;
                n_cnt = '0;
                n_pad = 1'b0;
            end
        end else if (w_code == b64d_pkg::CODE_BAD) begin
            w_cmd.cnt  = 2'd1;
            w_cmd.err  = 1'b1;
            w_cmd.last = 1'b1;
            w_has      = 1'b1;
            n_acc      = '0;
            n_cnt      = '0;
            n_err      = !i_end_of_text;
        end else if (w_code != b64d_pkg::CODE_PAD && w_code != b64d_pkg::CODE_SKIP
                     && r_cnt == 2'd3) begin
            // fourth sextet releases a full group
            w_cmd.data  = {r_acc, w_code[5:0]};
            w_cmd.cnt   = 2'd3;
            w_cmd.valid = 1'b1;
            w_cmd.last  = i_end_of_text;
            w_has       = 1'b1;
            n_acc       = '0;
            n_cnt       = '0;
        end else begin
            if (w_code != b64d_pkg::CODE_PAD && w_code != b64d_pkg::CODE_SKIP) begin
                w_acc = {r_acc[11:0], w_code[5:0]};
                w_cnt = r_cnt + 2'd1;
            end
            if (i_end_of_text) begin
                w_cmd = b64d_pkg::flush_cmd(w_acc, w_cnt);
                w_has = 1'b1;
                n_acc = '0;
                n_cnt = '0;
                n_pad = 1'b0;
            end else begin
                n_acc = w_acc;
                n_cnt = w_cnt;
                n_pad = (w_code == b64d_pkg::CODE_PAD);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_pad <= 1'b0;
            r_err <= 1'b0;
        end else if (i_accept) begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

    assign o_cmd_push = i_accept && w_has;
    assign o_cmd      = w_cmd;

endmodule

>>> design/b64d_queue.sv
// Command queue between the front and back ends.
// Small register file with read and write pointers. Uses b64d_pkg.
module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output b64d_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64d_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> design/b64d_back.sv
// Back end: expands each command word into its result words in an output
// register, one per cycle while it is empty or popped. Uses b64d_pkg.
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  b64d_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [7:0]     o_data_byte,
    output logic           o_byte_valid,
    output logic           o_decode_error,
    output logic           o_last
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_data;
    logic       r_bval, r_derr, r_last;

    logic       w_take, w_done;
    logic [7:0] w_byte;

    assign w_take = i_cmd_valid && (!r_out_valid || i_pop);
    assign w_done = (r_idx == i_cmd.cnt - 2'd1);

    always_comb begin
        case (r_idx)
            2'd0:    w_byte = i_cmd.data[23:16];
            2'd1:    w_byte = i_cmd.data[15:8];
            default: w_byte = i_cmd.data[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
                // advance through the command, release it on its final word
                r_idx       <= w_done ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_data <= w_byte;
            r_bval <= i_cmd.valid;
            r_derr <= i_cmd.err;
            r_last <= i_cmd.last && w_done;
        end
    end

    assign o_cmd_pop      = w_take && w_done;
    assign o_empty        = !r_out_valid;
    assign o_data_byte    = r_data;
    assign o_byte_valid   = r_bval;
    assign o_decode_error = r_derr;
    assign o_last         = r_last;

endmodule

>>> design/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, command queue, back end.
// Uses b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Takes one character per cycle while full is low and the command queue has
// room; each character that yields results becomes one queued command, which
// the back end drains at one result word per cycle while its output is free
// or popped (up to three per character, so a full group of four characters
// gives three words). The back end's single output register sets the output
// rate; QUEUE_DEPTH commands of slack let the input side keep running while
// results wait to be popped. A character's command is written into the queue,
// and its first result word then passes the back end's output register.
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    input  logic       i_end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_decode_error,
    output logic       o_last
);

    b64d_pkg::t_cmd w_front_cmd, w_head_cmd;
    logic           w_cmd_push, w_q_full, w_q_valid, w_cmd_pop, w_accept;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_cmd_push    (w_cmd_push),
        .o_cmd         (w_front_cmd)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_cmd_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    b64d_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_q_valid),
        .i_cmd          (w_head_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_data_byte    (o_data_byte),
        .o_byte_valid   (o_byte_valid),
        .o_decode_error (o_decode_error),
        .o_last         (o_last)
    );

endmodule
